// ===== design/mpld_pkg.sv =====
package mpld_pkg;

  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_W     = 9;
  localparam int CNT_W      = 20;
  localparam int STEP_W     = CNT_W + 1;
  localparam int MAG_W      = 10;
  localparam int IDX_W      = 2;
  localparam int CFG_W      = 20;
  localparam int FRAC_W     = 24;
  localparam int EXP_W      = 7;

  localparam logic [IDX_W-1:0] REG_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIST  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd2;

  localparam logic [CNT_W-1:0]  LIMIT_RST = CNT_W'(1000);
  localparam logic [HIST_W-1:0] HIST_RST  = HIST_W'(64);

  localparam logic [127:0] FOUR_Q120   = 128'h0400_0000_0000_0000_0000_0000_0000_0000;
  localparam logic [127:0] TINY_Q120   = 128'd132922799;
  localparam logic [31:0]  LOG10_2_Q32 = 32'h4D10_4D42;
  localparam logic [63:0]  G_SUB       = (64'd120 * {32'd0, LOG10_2_Q32}) << 24;
  localparam logic [63:0]  G_ADD       = 64'd28 << 56;

  typedef enum logic [1:0] {
    OUT_ESCAPED = 2'd0,
    OUT_CYCLE   = 2'd1,
    OUT_LIMIT   = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    OPD_ZR, OPD_ZI, OPD_DR, OPD_DI, OPD_M, OPD_LG, OPD_K, OPD_MID, OPD_ACC
  } opd_e;

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_TAKE_RE, DP_TAKE_IM, DP_RING_WR, DP_BEST_INIT,
    DP_DIFF_CUR, DP_DIFF_FAR, DP_UPD_FAR, DP_UPD_BEST, DP_LOG_BEST, DP_LOG_ACC,
    DP_LOG_NORM, DP_LOG_M, DP_LOG_STEP, DP_G_TAKE, DP_BS_MID, DP_BS_UPD, DP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    logic sgn;
    opd_e a_sel;
    opd_e b_sel;
    logic a_hi;
    logic b_hi;
  } mac_cmd_t;

  typedef struct packed {
    dp_op_e             op;
    mac_cmd_t           mac;
    logic [HIST_AW-1:0] addr;
    outcome_e           outcome;
    logic [CNT_W-1:0]   count;
    logic [HIST_W-1:0]  loop_len;
    logic               mag_en;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf;
    logic esc;
    logic match;
    logic tiny;
    logic norm_top;
    logic lo_lt_hi;
  } dp_stat_t;

endpackage

// ===== design/mpld_dpath.sv =====
module mpld_dpath import mpld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [63:0]         c_real_i,
  input  logic [63:0]         c_imag_i,
  input  logic [63:0]         start_real_i,
  input  logic [63:0]         start_imag_i,
  output logic [1:0]          outcome_o,
  output logic [CNT_W-1:0]    iteration_count_o,
  output logic [HIST_W-1:0]   loop_length_o,
  output logic [MAG_W-1:0]    diameter_magnitude_o,
  output logic [63:0]         final_real_o,
  output logic [63:0]         final_imag_o
);

  logic [127:0] ring_mem [HIST_DEPTH];
  logic [127:0] rd_q;

  logic [63:0]  cr_q, ci_q, zr_q, zi_q, tr_q, dr_q, di_q, far_r_q, far_i_q, m_q;
  logic         tr_fit_q;
  logic [127:0] e_q, best_q, norm_q, acc_q;
  logic [EXP_W-1:0]  n_q;
  logic [FRAC_W-1:0] frac_q;
  logic [31:0]  g_q;
  logic [MAG_W-1:0] lo_q, hi_q, mid_q;

  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic         neg_q, clr_q, en_q;

  logic [63:0]  opa, opb;
  logic [31:0]  a32, b32;
  logic         neg;
  logic [127:0] ext, acc_d;
  logic [68:0]  nr_w;
  logic [69:0]  ni_w;
  logic         nr_fit, ni_fit;
  logic [63:0]  nr_sat, ni_sat, mm, gs, gdiff;
  logic [MAG_W:0] mid_sum;
  logic [31:0]  lg_ext;

  function automatic logic [63:0] pick(input opd_e sel, input logic [63:0] zr,
                                       input logic [63:0] zi, input logic [63:0] dr,
                                       input logic [63:0] di, input logic [63:0] m,
                                       input logic [63:0] lg, input logic [63:0] mid,
                                       input logic [63:0] acc);
    logic [63:0] v;
    unique case (sel)
      OPD_ZR:  v = zr;
      OPD_ZI:  v = zi;
      OPD_DR:  v = dr;
      OPD_DI:  v = di;
      OPD_M:   v = m;
      OPD_LG:  v = lg;
      OPD_K:   v = {32'd0, LOG10_2_Q32};
      OPD_MID: v = mid;
      OPD_ACC: v = acc;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic is_signed(input opd_e sel);
    return (sel == OPD_ZR) || (sel == OPD_ZI) || (sel == OPD_DR) || (sel == OPD_DI);
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v, input logic s);
    return (s && v[63]) ? 64'd0 - v : v;
  endfunction

  always_comb begin
    logic [63:0] ra, rb, lgv, midv;
    lgv  = {33'd0, n_q, frac_q};
    midv = {{(64-MAG_W){1'b0}}, mid_q};
    ra = pick(cmd_i.mac.a_sel, zr_q, zi_q, dr_q, di_q, m_q, lgv, midv, acc_q[63:0]);
    rb = pick(cmd_i.mac.b_sel, zr_q, zi_q, dr_q, di_q, m_q, lgv, midv, acc_q[63:0]);
    opa = mag64(ra, is_signed(cmd_i.mac.a_sel));
    opb = mag64(rb, is_signed(cmd_i.mac.b_sel));
    neg = cmd_i.mac.sub ^ (cmd_i.mac.sgn & (ra[63] ^ rb[63]));
  end

  assign a32 = cmd_i.mac.a_hi ? opa[63:32] : opa[31:0];
  assign b32 = cmd_i.mac.b_hi ? opb[63:32] : opb[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    ext = {64'd0, prod_q};
      2'd1:    ext = {32'd0, prod_q, 32'd0};
      2'd2:    ext = {prod_q, 64'd0};
      default: ext = '0;
    endcase
    acc_d = (clr_q ? 128'd0 : acc_q) + (neg_q ? 128'd0 - ext : ext);
  end

  // next z from the accumulated products
  assign nr_w   = {acc_q[127], acc_q[127:60]} + {{5{cr_q[63]}}, cr_q};
  assign ni_w   = {acc_q[127], acc_q[127:59]} + {{6{ci_q[63]}}, ci_q};
  assign nr_fit = (&nr_w[68:63]) || !(|nr_w[68:63]);
  assign ni_fit = (&ni_w[69:63]) || !(|ni_w[69:63]);
  assign nr_sat = nr_fit ? nr_w[63:0] : (nr_w[68] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
  assign ni_sat = ni_fit ? ni_w[63:0] : (ni_w[69] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

  assign mm      = acc_q[125:62];
  assign gs      = acc_q[63:0] + G_ADD;
  assign gdiff   = gs - G_SUB;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (MAG_W+1)'(1);
  assign lg_ext  = {1'b0, n_q, frac_q};

  assign stat_o.ovf      = !tr_fit_q || !ni_fit;
  assign stat_o.esc      = acc_q > FOUR_Q120;
  assign stat_o.match    = rd_q == {zr_q, zi_q};
  assign stat_o.tiny     = best_q <= TINY_Q120;
  assign stat_o.norm_top = norm_q[127];
  assign stat_o.lo_lt_hi = lo_q < hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RING_WR) begin
      ring_mem[cmd_i.addr] <= {zr_q, zi_q};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ring_mem[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= cmd_i.mac.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a32 * b32;
    sh_q   <= {1'b0, cmd_i.mac.a_hi} + {1'b0, cmd_i.mac.b_hi};
    neg_q  <= neg;
    clr_q  <= cmd_i.mac.clr;
    if (en_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_NONE: ;
      DP_LOAD: begin
        cr_q <= c_real_i;
        ci_q <= c_imag_i;
        zr_q <= start_real_i;
        zi_q <= start_imag_i;
      end
      DP_TAKE_RE: begin
        tr_q     <= nr_sat;
        tr_fit_q <= nr_fit;
      end
      DP_TAKE_IM: begin
        zr_q <= tr_q;
        zi_q <= ni_sat;
      end
      DP_RING_WR: ;
      DP_BEST_INIT: begin
        best_q  <= '0;
        far_r_q <= zr_q;
        far_i_q <= zi_q;
      end
      DP_DIFF_CUR: begin
        dr_q <= rd_q[127:64] - zr_q;
        di_q <= rd_q[63:0] - zi_q;
        e_q  <= rd_q;
      end
      DP_DIFF_FAR: begin
        dr_q <= rd_q[127:64] - far_r_q;
        di_q <= rd_q[63:0] - far_i_q;
      end
      DP_UPD_FAR: begin
        if (acc_q > best_q) begin
          best_q  <= acc_q;
          far_r_q <= e_q[127:64];
          far_i_q <= e_q[63:0];
        end
      end
      DP_UPD_BEST: begin
        if (acc_q > best_q) begin
          best_q <= acc_q;
        end
      end
      DP_LOG_BEST: begin
        norm_q <= best_q;
        n_q    <= '1;
      end
      DP_LOG_ACC: begin
        norm_q <= acc_q;
        n_q    <= '1;
      end
      DP_LOG_NORM: begin
        if (!norm_q[127]) begin
          norm_q <= {norm_q[126:0], 1'b0};
          n_q    <= n_q - EXP_W'(1);
        end
      end
      DP_LOG_M: begin
        m_q    <= {1'b0, norm_q[127:65]};
        frac_q <= '0;
      end
      DP_LOG_STEP: begin
        frac_q <= {frac_q[FRAC_W-2:0], mm[63]};
        m_q    <= mm[63] ? {1'b0, mm[63:1]} : mm;
      end
      DP_G_TAKE: begin
        g_q  <= (gs > G_SUB) ? gdiff[63:32] : 32'd0;
        lo_q <= MAG_W'(1);
        hi_q <= '1;
      end
      DP_BS_MID: mid_q <= mid_sum[MAG_W:1];
      DP_BS_UPD: begin
        if (lg_ext <= g_q) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q - MAG_W'(1);
        end
      end
      DP_FINISH: begin
        outcome_o            <= cmd_i.outcome;
        iteration_count_o    <= cmd_i.count;
        loop_length_o        <= cmd_i.loop_len;
        diameter_magnitude_o <= cmd_i.mag_en ? lo_q : '0;
        final_real_o         <= zr_q;
        final_imag_o         <= zi_q;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/mpld_ctrl.sv =====
module mpld_ctrl import mpld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  dp_stat_t           stat_i,
  output dp_cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_XX, S_YY, S_DR_RE, S_TAKE_RE, S_XY, S_DR_IM, S_TAKE_IM,
    S_NX, S_NY, S_DR_ESC, S_ESC, S_CHK_RD, S_CHK_CMP, S_WRITE,
    S_P_RD, S_P_DIFF, S_P_MR, S_P_MI, S_P_DR, S_P_UPD, S_TINY,
    S_LG_INIT, S_LG_NORM, S_LG_M, S_LG_SQ, S_LG_DR, S_LG_STEP,
    S_G_MUL, S_G_DR, S_G_TAKE, S_BS_TEST, S_BS_MID, S_BS_SQ, S_BS_SQDR,
    S_BS_CU, S_BS_CUDR, S_BS_CMP, S_FINISH
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   limit_q;
  logic [HIST_W-1:0]  hist_q;
  logic               mode_q;
  logic [STEP_W-1:0]  step_q;
  logic [HIST_AW-1:0] pos_q, j_q, k_q;
  logic               seen_q, pass_q, logsrc_q, lgret_q, done_q, magen_q;
  logic [1:0]         cnt_q;
  logic [4:0]         fcnt_q;
  outcome_e           outcome_q;
  logic [CNT_W-1:0]   count_q;
  logic [HIST_W-1:0]  loop_q;

  logic [HIST_W-1:0]  len;
  logic [HIST_W-1:0]  len_m1_w;
  logic [HIST_AW-1:0] len_m1, pos_inc;
  logic [STEP_W-1:0]  step_inc;
  logic               check_due, over;
  logic [CNT_W-1:0]   esc_count;

  assign len       = (hist_q > HIST_W'(HIST_DEPTH)) ? HIST_W'(HIST_DEPTH) : hist_q;
  assign len_m1_w  = len - HIST_W'(1);
  assign len_m1    = len_m1_w[HIST_AW-1:0];
  assign pos_inc   = ((HIST_W'(pos_q) + HIST_W'(1)) == len) ? '0 : pos_q + HIST_AW'(1);
  assign step_inc  = step_q + STEP_W'(1);
  assign over      = step_inc > {1'b0, limit_q};
  assign check_due = (len != '0) && (step_q != '0) && (pos_q == '0);
  assign esc_count = (step_q == '0) ? CNT_W'(1) : step_q[CNT_W-1:0];

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      hist_q  <= HIST_RST;
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIMIT: limit_q <= cfg_data_i[CNT_W-1:0];
        REG_HIST:  hist_q  <= cfg_data_i[HIST_W-1:0];
        REG_MODE:  mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_o.op        = DP_NONE;
    cmd_o.mac.en    = 1'b0;
    cmd_o.mac.clr   = 1'b0;
    cmd_o.mac.sub   = 1'b0;
    cmd_o.mac.sgn   = 1'b0;
    cmd_o.mac.a_sel = OPD_ZR;
    cmd_o.mac.b_sel = OPD_ZR;
    cmd_o.mac.a_hi  = cnt_q[1];
    cmd_o.mac.b_hi  = cnt_q[0];
    cmd_o.addr      = k_q;
    cmd_o.outcome   = outcome_q;
    cmd_o.count     = count_q;
    cmd_o.loop_len  = loop_q;
    cmd_o.mag_en    = magen_q;
    unique case (state_q)
      S_IDLE: if (start_i) cmd_o.op = DP_LOAD;
      S_XX, S_NX: begin
        cmd_o.mac.en  = 1'b1;
        cmd_o.mac.clr = cnt_q == 2'd0;
      end
      S_YY, S_NY: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.sub   = state_q == S_YY;
        cmd_o.mac.a_sel = OPD_ZI;
        cmd_o.mac.b_sel = OPD_ZI;
      end
      S_TAKE_RE: cmd_o.op = DP_TAKE_RE;
      S_XY: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = cnt_q == 2'd0;
        cmd_o.mac.sgn   = 1'b1;
        cmd_o.mac.b_sel = OPD_ZI;
      end
      S_TAKE_IM: cmd_o.op = DP_TAKE_IM;
      S_CHK_RD: cmd_o.addr = j_q;
      S_CHK_CMP: begin
        cmd_o.addr = j_q;
        if (stat_i.match && seen_q && !mode_q) cmd_o.op = DP_BEST_INIT;
      end
      S_WRITE: begin
        cmd_o.addr = pos_q;
        if (len != '0) cmd_o.op = DP_RING_WR;
      end
      S_P_DIFF: cmd_o.op = pass_q ? DP_DIFF_FAR : DP_DIFF_CUR;
      S_P_MR: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = cnt_q == 2'd0;
        cmd_o.mac.a_sel = OPD_DR;
        cmd_o.mac.b_sel = OPD_DR;
      end
      S_P_MI: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.a_sel = OPD_DI;
        cmd_o.mac.b_sel = OPD_DI;
      end
      S_P_UPD: cmd_o.op = pass_q ? DP_UPD_BEST : DP_UPD_FAR;
      S_LG_INIT: cmd_o.op = logsrc_q ? DP_LOG_ACC : DP_LOG_BEST;
      S_LG_NORM: cmd_o.op = DP_LOG_NORM;
      S_LG_M:    cmd_o.op = DP_LOG_M;
      S_LG_SQ: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = cnt_q == 2'd0;
        cmd_o.mac.a_sel = OPD_M;
        cmd_o.mac.b_sel = OPD_M;
      end
      S_LG_STEP: cmd_o.op = DP_LOG_STEP;
      S_G_MUL: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = 1'b1;
        cmd_o.mac.a_sel = OPD_LG;
        cmd_o.mac.b_sel = OPD_K;
      end
      S_G_TAKE: cmd_o.op = DP_G_TAKE;
      S_BS_MID: cmd_o.op = DP_BS_MID;
      S_BS_SQ: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = 1'b1;
        cmd_o.mac.a_sel = OPD_MID;
        cmd_o.mac.b_sel = OPD_MID;
      end
      S_BS_CU: begin
        cmd_o.mac.en    = 1'b1;
        cmd_o.mac.clr   = 1'b1;
        cmd_o.mac.a_sel = OPD_ACC;
        cmd_o.mac.b_sel = OPD_MID;
      end
      S_BS_CMP: cmd_o.op = DP_BS_UPD;
      S_FINISH: cmd_o.op = DP_FINISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      pos_q     <= '0;
      j_q       <= '0;
      k_q       <= '0;
      seen_q    <= 1'b0;
      pass_q    <= 1'b0;
      logsrc_q  <= 1'b0;
      lgret_q   <= 1'b0;
      done_q    <= 1'b0;
      magen_q   <= 1'b0;
      cnt_q     <= '0;
      fcnt_q    <= '0;
      outcome_q <= OUT_ESCAPED;
      count_q   <= '0;
      loop_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            step_q  <= '0;
            pos_q   <= '0;
            seen_q  <= 1'b0;
            state_q <= S_XX;
          end
        end
        S_XX: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_YY;
        end
        S_YY: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_DR_RE;
        end
        S_DR_RE:   state_q <= S_TAKE_RE;
        S_TAKE_RE: state_q <= S_XY;
        S_XY: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_DR_IM;
        end
        S_DR_IM: state_q <= S_TAKE_IM;
        S_TAKE_IM: begin
          if (stat_i.ovf) begin
            outcome_q <= OUT_ESCAPED;
            count_q   <= esc_count;
            loop_q    <= '0;
            magen_q   <= 1'b0;
            state_q   <= S_FINISH;
          end else begin
            state_q <= S_NX;
          end
        end
        S_NX: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_NY;
        end
        S_NY: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_DR_ESC;
        end
        S_DR_ESC: state_q <= S_ESC;
        S_ESC: begin
          if (stat_i.esc) begin
            outcome_q <= OUT_ESCAPED;
            count_q   <= esc_count;
            loop_q    <= '0;
            magen_q   <= 1'b0;
            state_q   <= S_FINISH;
          end else if (check_due) begin
            j_q     <= len_m1;
            state_q <= S_CHK_RD;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_CHK_RD: state_q <= S_CHK_CMP;
        S_CHK_CMP: begin
          if (stat_i.match) begin
            if (!seen_q) begin
              seen_q  <= 1'b1;
              state_q <= S_WRITE;
            end else begin
              outcome_q <= OUT_CYCLE;
              count_q   <= '0;
              loop_q    <= len - {1'b0, j_q};
              magen_q   <= !mode_q;
              if (mode_q) begin
                state_q <= S_FINISH;
              end else begin
                pass_q  <= 1'b0;
                k_q     <= len_m1;
                state_q <= S_P_RD;
              end
            end
          end else if (j_q == '0) begin
            state_q <= S_WRITE;
          end else begin
            j_q     <= j_q - HIST_AW'(1);
            state_q <= S_CHK_RD;
          end
        end
        S_WRITE: begin
          if (len != '0) pos_q <= pos_inc;
          step_q <= step_inc;
          if (over) begin
            outcome_q <= OUT_LIMIT;
            count_q   <= limit_q;
            loop_q    <= '0;
            magen_q   <= 1'b0;
            state_q   <= S_FINISH;
          end else begin
            state_q <= S_XX;
          end
        end
        S_P_RD:   state_q <= S_P_DIFF;
        S_P_DIFF: state_q <= S_P_MR;
        S_P_MR: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_P_MI;
        end
        S_P_MI: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_P_DR;
        end
        S_P_DR: state_q <= S_P_UPD;
        S_P_UPD: begin
          if (k_q == j_q) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              k_q     <= len_m1;
              state_q <= S_P_RD;
            end else begin
              state_q <= S_TINY;
            end
          end else begin
            k_q     <= k_q - HIST_AW'(1);
            state_q <= S_P_RD;
          end
        end
        S_TINY: begin
          if (stat_i.tiny) begin
            magen_q <= 1'b0;
            state_q <= S_FINISH;
          end else begin
            logsrc_q <= 1'b0;
            lgret_q  <= 1'b0;
            state_q  <= S_LG_INIT;
          end
        end
        S_LG_INIT: state_q <= S_LG_NORM;
        S_LG_NORM: if (stat_i.norm_top) state_q <= S_LG_M;
        S_LG_M: begin
          fcnt_q  <= '0;
          state_q <= S_LG_SQ;
        end
        S_LG_SQ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_LG_DR;
        end
        S_LG_DR: state_q <= S_LG_STEP;
        S_LG_STEP: begin
          if (fcnt_q == 5'(FRAC_W - 1)) begin
            state_q <= lgret_q ? S_BS_CMP : S_G_MUL;
          end else begin
            fcnt_q  <= fcnt_q + 5'd1;
            state_q <= S_LG_SQ;
          end
        end
        S_G_MUL:  state_q <= S_G_DR;
        S_G_DR:   state_q <= S_G_TAKE;
        S_G_TAKE: state_q <= S_BS_TEST;
        S_BS_TEST: state_q <= stat_i.lo_lt_hi ? S_BS_MID : S_FINISH;
        S_BS_MID:  state_q <= S_BS_SQ;
        S_BS_SQ:   state_q <= S_BS_SQDR;
        S_BS_SQDR: state_q <= S_BS_CU;
        S_BS_CU:   state_q <= S_BS_CUDR;
        S_BS_CUDR: begin
          logsrc_q <= 1'b1;
          lgret_q  <= 1'b1;
          state_q  <= S_LG_INIT;
        end
        S_BS_CMP: state_q <= S_BS_TEST;
        S_FINISH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_FINISH))
    else $error("result strobe without a finishing step");

  a_start_enters_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> state_q == S_XX)
    else $error("accepted word did not start iterating");

  a_ring_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_RING_WR) |-> (HIST_W'(pos_q) < len))
    else $error("ring write beyond history length");

  a_cycle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && outcome_q == OUT_CYCLE) |-> (loop_q != '0 && count_q == '0))
    else $error("cycle result with bad length or count");

endmodule

// ===== design/mandelbrot_point_loop_detect.sv =====
// run time: grows with the iterations, with the ring entries read at each check,
//   with the entries in the cycle span and with the log2 runs of the diameter search
// throughput: one point at a time, the next start is taken once busy is low;
//   every product is formed by the single shared 32x32 multiply-accumulate unit
// reset: limit 1000, history 64, full mode, controller idle, ring left uncleared
// results are strobed on done_o for one cycle; the receiver cannot stall
module mandelbrot_point_loop_detect import mpld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [63:0]        c_real_i,
  input  logic [63:0]        c_imag_i,
  input  logic [63:0]        start_real_i,
  input  logic [63:0]        start_imag_i,
  output logic               done_o,
  output logic [1:0]         outcome_o,
  output logic [CNT_W-1:0]   iteration_count_o,
  output logic [HIST_W-1:0]  loop_length_o,
  output logic [MAG_W-1:0]   diameter_magnitude_o,
  output logic [63:0]        final_real_o,
  output logic [63:0]        final_imag_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mpld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .done_o     (done_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mpld_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .c_real_i             (c_real_i),
    .c_imag_i             (c_imag_i),
    .start_real_i         (start_real_i),
    .start_imag_i         (start_imag_i),
    .outcome_o            (outcome_o),
    .iteration_count_o    (iteration_count_o),
    .loop_length_o        (loop_length_o),
    .diameter_magnitude_o (diameter_magnitude_o),
    .final_real_o         (final_real_o),
    .final_imag_o         (final_imag_o)
  );

endmodule
